// ===== rtl/aim_sweep_and_fire_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// aim sweep and fire sequencer assertion macros
// concurrent assertion wrappers, empty when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef AIM_SWEEP_AND_FIRE_SEQUENCER_MACROS_SVH
`define AIM_SWEEP_AND_FIRE_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/asf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_pkg
// shared types, microcode rom, coefficients and angle table
// ----------------------------------------------------------------------------
package asf_pkg;

  localparam int unsigned ColW     = 10;
  localparam int unsigned CmpW     = 15;
  localparam int unsigned DistW    = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned StepW    = 5;
  localparam int unsigned DW       = 28;  // distance in q24 meters
  localparam int unsigned MagW     = 39;  // horner magnitude, q15.24
  localparam int unsigned LoW      = 28;
  localparam int unsigned RW       = 44;
  localparam int unsigned SumW     = 46;
  localparam int unsigned ElevW    = 15;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned CoefSelW = 3;
  localparam int unsigned TgtW     = 7;
  localparam int unsigned OfsW     = 9;

  typedef struct packed {
    logic [ColW-1:0] target_column;
    logic            hold_sweep;
  } asf_tick_t;

  typedef struct packed {
    logic [CmpW-1:0] pan_compare;
    logic [CmpW-1:0] tilt_compare;
    logic            charge_relay;
    logic            discharge_relay;
    logic            shoot_request;
  } asf_result_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_SWEEP  = 2'd2
  } asf_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE_SELECT        = 3'd0,
    REG_RUN_ENABLE         = 3'd1,
    REG_TARGET_DISTANCE_CM = 3'd2,
    REG_MANUAL_PAN_DEGREES = 3'd3,
    REG_AIM_COLUMN         = 3'd4,
    REG_PAN_CENTER         = 3'd5,
    REG_TILT_CENTER        = 3'd6
  } asf_reg_e;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_DIST   = 3'd1,
    OP_MUL_LO = 3'd2,
    OP_MUL_HI = 3'd3,
    OP_ACC    = 3'd4,
    OP_UPDATE = 3'd5,
    OP_SERVO  = 3'd6
  } asf_op_e;

  typedef enum logic [1:0] {
    JMP_NONE    = 2'd0,
    JMP_NO_POLY = 2'd1,
    JMP_ALWAYS  = 2'd2
  } asf_jmp_e;

  typedef struct packed {
    asf_op_e              op;
    logic [CoefSelW-1:0]  coef_sel;
    asf_jmp_e             jmp;
    logic [StepW-1:0]     target;
  } asf_uword_t;

  localparam logic [StepW-1:0] STEP_FIRST  = 5'd0;
  localparam logic [StepW-1:0] STEP_UPDATE = 5'd16;
  localparam logic [StepW-1:0] STEP_SERVO  = 5'd17;

  // d = floor(dist * 2^22 / 25) = dist*167772 + floor(dist*4/25)
  localparam logic [DW-1:0] DIST_MUL_HI = 28'd167772;
  localparam logic [22:0]   DIST_MUL_LO = 23'd5244;  // 4 * 1311, then >> 15

  localparam logic [MagW-1:0]        H_INIT  = 39'd3028287;
  localparam logic [MagW-1:0]        Q_MAX   = 39'h7FFFFFFFFF;
  localparam logic signed [SumW-1:0] Q_MAX_S = 46'sd549755813887;

  localparam logic [CmpW-1:0] CMP_MAX = 15'h7FFF;

  // trunc(a * 1000 / 135) for a = 0 .. 39
  localparam logic [OfsW-1:0] OFS_TABLE [40] = '{
    9'd0,   9'd7,   9'd14,  9'd22,  9'd29,  9'd37,  9'd44,  9'd51,
    9'd59,  9'd66,  9'd74,  9'd81,  9'd88,  9'd96,  9'd103, 9'd111,
    9'd118, 9'd125, 9'd133, 9'd140, 9'd148, 9'd155, 9'd162, 9'd170,
    9'd177, 9'd185, 9'd192, 9'd200, 9'd207, 9'd214, 9'd222, 9'd229,
    9'd237, 9'd244, 9'd251, 9'd259, 9'd266, 9'd274, 9'd281, 9'd288
  };

  // horner coefficients in q24, sign folded in
  function automatic logic signed [CoefW-1:0] coef(input logic [CoefSelW-1:0] sel);
    logic signed [CoefW-1:0] c;
    case (sel)
      3'd0:    c = -32'sd35517366;
      3'd1:    c =  32'sd174650819;
      3'd2:    c = -32'sd445602857;
      3'd3:    c =  32'sd748599378;
      3'd4:    c = -32'sd470600909;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic asf_uword_t uw(input asf_op_e op, input logic [CoefSelW-1:0] cs,
                                    input asf_jmp_e j, input logic [StepW-1:0] t);
    asf_uword_t w;
    w.op       = op;
    w.coef_sel = cs;
    w.jmp      = j;
    w.target   = t;
    return w;
  endfunction

  // control program: distance, five horner passes, state update, servo write
  function automatic asf_uword_t ucode(input logic [StepW-1:0] step);
    asf_uword_t w;
    case (step)
      5'd0:    w = uw(OP_DIST,   3'd0, JMP_NO_POLY, STEP_UPDATE);
      5'd1:    w = uw(OP_MUL_LO, 3'd0, JMP_NONE,    STEP_FIRST);
      5'd2:    w = uw(OP_MUL_HI, 3'd0, JMP_NONE,    STEP_FIRST);
      5'd3:    w = uw(OP_ACC,    3'd0, JMP_NONE,    STEP_FIRST);
      5'd4:    w = uw(OP_MUL_LO, 3'd0, JMP_NONE,    STEP_FIRST);
      5'd5:    w = uw(OP_MUL_HI, 3'd0, JMP_NONE,    STEP_FIRST);
      5'd6:    w = uw(OP_ACC,    3'd1, JMP_NONE,    STEP_FIRST);
      5'd7:    w = uw(OP_MUL_LO, 3'd0, JMP_NONE,    STEP_FIRST);
      5'd8:    w = uw(OP_MUL_HI, 3'd0, JMP_NONE,    STEP_FIRST);
      5'd9:    w = uw(OP_ACC,    3'd2, JMP_NONE,    STEP_FIRST);
      5'd10:   w = uw(OP_MUL_LO, 3'd0, JMP_NONE,    STEP_FIRST);
      5'd11:   w = uw(OP_MUL_HI, 3'd0, JMP_NONE,    STEP_FIRST);
      5'd12:   w = uw(OP_ACC,    3'd3, JMP_NONE,    STEP_FIRST);
      5'd13:   w = uw(OP_MUL_LO, 3'd0, JMP_NONE,    STEP_FIRST);
      5'd14:   w = uw(OP_MUL_HI, 3'd0, JMP_NONE,    STEP_FIRST);
      5'd15:   w = uw(OP_ACC,    3'd4, JMP_NONE,    STEP_FIRST);
      5'd16:   w = uw(OP_UPDATE, 3'd0, JMP_NONE,    STEP_FIRST);
      5'd17:   w = uw(OP_SERVO,  3'd0, JMP_NONE,    STEP_FIRST);
      default: w = uw(OP_NOP,    3'd0, JMP_ALWAYS,  STEP_SERVO);
    endcase
    return w;
  endfunction

  // center + trunc(angle*1000/135), saturated to the compare range
  function automatic logic [CmpW-1:0] to_compare(input logic [CmpW-1:0] center,
                                                 input logic signed [TgtW-1:0] ang);
    logic signed [TgtW-1:0] mag;
    logic [OfsW-1:0]        ofs;
    logic signed [CmpW+1:0] v;
    mag = (ang < 0) ? -ang : ang;
    ofs = OFS_TABLE[mag[5:0]];
    if (ang < 0) begin
      v = $signed({2'b00, center}) - $signed({8'd0, ofs});
    end else begin
      v = $signed({2'b00, center}) + $signed({8'd0, ofs});
    end
    if (v < 0) begin
      return '0;
    end else if (v > $signed({2'b00, CMP_MAX})) begin
      return CMP_MAX;
    end
    return v[CmpW-1:0];
  endfunction

endpackage

// ===== rtl/asf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf channel interfaces
// valid/ready channels for control ticks and servo/relay results
// ----------------------------------------------------------------------------
interface asf_tick_if;
  logic                valid;
  logic                ready;
  asf_pkg::asf_tick_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface asf_result_if;
  logic                 valid;
  logic                 ready;
  asf_pkg::asf_result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/asf_poly.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_poly
// horner datapath for the elevation polynomial, driven by the control word
// ----------------------------------------------------------------------------
module asf_poly (
  input  logic                         clk_i,
  input  asf_pkg::asf_uword_t          uword_i,
  input  logic [asf_pkg::DistW-1:0]    dist_i,
  output logic [asf_pkg::ElevW-1:0]    elev_mag_o,
  output logic                         elev_neg_o
);

  logic [asf_pkg::DW-1:0]   d_q, d_d;
  logic [asf_pkg::MagW-1:0] m_q, m_d;
  logic                     neg_q, neg_d;
  logic [asf_pkg::LoW-1:0]  lo_q, lo_d;
  logic [asf_pkg::RW-1:0]   r_q, r_d;

  logic [asf_pkg::DW-1:0]       dist_hi;
  logic [22:0]                  dist_lo;
  logic [51:0]                  lo_prod;
  logic [asf_pkg::RW-1:0]       hi_prod;
  logic signed [asf_pkg::CoefW-1:0] c;
  logic signed [asf_pkg::SumW-1:0]  c_s, r_s, pos_sum, neg_sum;

  assign dist_hi = asf_pkg::DW'(dist_i) * asf_pkg::DIST_MUL_HI;
  assign dist_lo = 23'(dist_i) * asf_pkg::DIST_MUL_LO;

  // |h| split at the binary point: low 24 bits and high 15 bits
  assign lo_prod = 52'(m_q[23:0]) * 52'(d_q);
  assign hi_prod = asf_pkg::RW'(m_q[asf_pkg::MagW-1:24]) * asf_pkg::RW'(d_q);

  assign c       = asf_pkg::coef(uword_i.coef_sel);
  assign c_s     = {{(asf_pkg::SumW-asf_pkg::CoefW){c[asf_pkg::CoefW-1]}}, c};
  assign r_s     = $signed({2'b00, r_q});
  // signed sum and its negation side by side, for sign-magnitude storage
  assign pos_sum = neg_q ? (c_s - r_s) : (c_s + r_s);
  assign neg_sum = neg_q ? (r_s - c_s) : (-c_s - r_s);

  always_comb begin
    d_d   = d_q;
    m_d   = m_q;
    neg_d = neg_q;
    lo_d  = lo_q;
    r_d   = r_q;
    case (uword_i.op)
      asf_pkg::OP_DIST: begin
        d_d   = dist_hi + asf_pkg::DW'(dist_lo[22:15]);
        m_d   = asf_pkg::H_INIT;
        neg_d = 1'b0;
      end
      asf_pkg::OP_MUL_LO: begin
        lo_d = lo_prod[51:24];
      end
      asf_pkg::OP_MUL_HI: begin
        r_d = hi_prod + asf_pkg::RW'(lo_q);
      end
      asf_pkg::OP_ACC: begin
        if (pos_sum > asf_pkg::Q_MAX_S) begin
          m_d   = asf_pkg::Q_MAX;
          neg_d = 1'b0;
        end else if (pos_sum < -asf_pkg::Q_MAX_S) begin
          m_d   = asf_pkg::Q_MAX;
          neg_d = 1'b1;
        end else if (pos_sum < 0) begin
          m_d   = neg_sum[asf_pkg::MagW-1:0];
          neg_d = 1'b1;
        end else begin
          m_d   = pos_sum[asf_pkg::MagW-1:0];
          neg_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    m_q   <= m_d;
    neg_q <= neg_d;
    lo_q  <= lo_d;
    r_q   <= r_d;
  end

  // truncation toward zero to whole degrees
  assign elev_mag_o = m_q[asf_pkg::MagW-1:24];
  assign elev_neg_o = neg_q;

endmodule

// ===== rtl/aim_sweep_and_fire_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aim_sweep_and_fire_sequencer
// per-tick servo compare and relay sequencer with polynomial elevation aim
// ----------------------------------------------------------------------------
// One tick item in gives one result item out. A small microcode program
// steps a plain datapath: distance scaling, five horner passes of the
// elevation polynomial (three steps each: low partial product, high partial
// product, coefficient add with saturation), a state update step and a servo
// write step. In manual aim with run enabled and a nonzero distance an item
// runs every step; every other case jumps from the distance step over the
// polynomial to the update step. The polynomial loop, with its 24x28 and
// 15x28 multiplies, makes the first case the longer one. The input side is
// free again as soon as the result sits in the output register, so a result
// that is not taken yet only stalls the servo write step of the following
// item. Configuration writes are taken at any edge with cfg_we_i high.

`include "aim_sweep_and_fire_sequencer_macros.svh"

module aim_sweep_and_fire_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [asf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [asf_pkg::CfgDataW-1:0]  cfg_data_i,
  asf_tick_if.sink                      tick_i,
  asf_result_if.source                  result_o
);

  // relay sequence phases
  localparam logic [2:0] PH_DISCHARGE = 3'd1;
  localparam logic [2:0] PH_CHARGE    = 3'd2;
  localparam logic [2:0] PH_SETTLE    = 3'd3;
  localparam logic [2:0] PH_ARMED     = 3'd4;
  localparam logic [2:0] PH_DONE      = 3'd5;

  localparam logic [7:0] DIS_TICKS    = 8'd20;
  localparam logic [7:0] CHG_TICKS    = 8'd150;
  localparam logic [7:0] SETTLE_TICKS = 8'd100;
  localparam logic [7:0] FIRE_TICKS   = 8'd100;
  localparam logic [7:0] SWEEP_PERIOD = 8'd6;

  localparam logic signed [8:0]  SWEEP_LIMIT = 9'sd30;
  localparam logic signed [8:0]  SWEEP_STEP  = 9'sd2;
  localparam logic signed [8:0]  ANGLE_LIMIT = 9'sd40;
  localparam logic signed [10:0] WINDOW      = 11'sd55;
  localparam logic [asf_pkg::ElevW-1:0] TILT_FIXED = 15'd20;
  localparam logic [asf_pkg::ElevW-1:0] ELEV_LIMIT = 15'd40;

  // configuration registers
  logic [1:0]                  mode_q;
  logic                        run_q;
  logic [asf_pkg::DistW-1:0]   dist_q;
  logic signed [7:0]           man_pan_q;
  logic [asf_pkg::ColW-1:0]    aim_q;
  logic [asf_pkg::CmpW-1:0]    pan_ctr_q;
  logic [asf_pkg::CmpW-1:0]    tilt_ctr_q;

  // sequencer
  logic                        busy_q, busy_d;
  logic [asf_pkg::StepW-1:0]   step_q, step_d;
  asf_pkg::asf_uword_t         uw, uw_eff;
  logic                        tick_accept, out_free, servo_fire, do_update, poly_needed;

  // latched tick
  logic [asf_pkg::ColW-1:0]    col_q;
  logic                        hold_q;

  // block state
  logic [asf_pkg::CmpW-1:0]    pan_value_q, pan_value_d;
  logic [asf_pkg::CmpW-1:0]    tilt_value_q, tilt_value_d;
  logic signed [8:0]           sweep_angle_q, sweep_angle_d;
  logic [7:0]                  sweep_tick_q, sweep_tick_d;
  logic                        sweep_rising_q, sweep_rising_d;
  logic [2:0]                  fire_phase_q, fire_phase_d;
  logic [7:0]                  phase_ticks_q, phase_ticks_d;
  logic                        firing_q, firing_d;
  logic                        charge_on_q, charge_on_d;
  logic                        discharge_on_q, discharge_on_d;
  logic                        shoot_q, shoot_d;

  // servo requests handed from the update step to the servo step
  logic signed [asf_pkg::TgtW-1:0] pan_tgt_q, pan_tgt_d;
  logic signed [asf_pkg::TgtW-1:0] tilt_tgt_q, tilt_tgt_d;
  logic                            pan_go_q, pan_go_d;
  logic                            tilt_go_q, tilt_go_d;

  // update step scratch
  logic signed [8:0]               pan_ang;
  logic                            pan_en;
  logic [asf_pkg::ElevW-1:0]       tilt_mag;
  logic                            tilt_neg;
  logic                            tilt_en;
  logic signed [asf_pkg::TgtW-1:0] tilt_small;
  logic signed [10:0]              col_diff;

  logic [asf_pkg::ElevW-1:0]       elev_mag;
  logic                            elev_neg;

  // output register
  logic                            out_valid_q;
  asf_pkg::asf_result_t            out_q, out_d;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= asf_pkg::MODE_IDLE;
      run_q      <= 1'b0;
      dist_q     <= '0;
      man_pan_q  <= '0;
      aim_q      <= 10'd183;
      pan_ctr_q  <= 15'd1680;
      tilt_ctr_q <= 15'd1300;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        asf_pkg::REG_MODE_SELECT:        mode_q     <= cfg_data_i[1:0];
        asf_pkg::REG_RUN_ENABLE:         run_q      <= cfg_data_i[0];
        asf_pkg::REG_TARGET_DISTANCE_CM: dist_q     <= cfg_data_i[asf_pkg::DistW-1:0];
        asf_pkg::REG_MANUAL_PAN_DEGREES: man_pan_q  <= $signed(cfg_data_i[7:0]);
        asf_pkg::REG_AIM_COLUMN:         aim_q      <= cfg_data_i[asf_pkg::ColW-1:0];
        asf_pkg::REG_PAN_CENTER:         pan_ctr_q  <= cfg_data_i;
        asf_pkg::REG_TILT_CENTER:        tilt_ctr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- sequencer
  assign uw          = asf_pkg::ucode(step_q);
  assign tick_i.ready = !busy_q;
  assign tick_accept = tick_i.valid && !busy_q;
  assign out_free    = !out_valid_q || result_o.ready;
  assign servo_fire  = busy_q && (uw.op == asf_pkg::OP_SERVO) && out_free;
  assign do_update   = busy_q && (uw.op == asf_pkg::OP_UPDATE);
  assign poly_needed = (mode_q == asf_pkg::MODE_MANUAL) && run_q && (dist_q != '0);

  // datapath sees a no-op while idle
  always_comb begin
    uw_eff = uw;
    if (!busy_q) begin
      uw_eff.op = asf_pkg::OP_NOP;
    end
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (tick_accept) begin
      busy_d = 1'b1;
      step_d = asf_pkg::STEP_FIRST;
    end else if (busy_q) begin
      if (uw.op == asf_pkg::OP_SERVO) begin
        // wait here until the output register can take the result
        if (out_free) begin
          busy_d = 1'b0;
          step_d = asf_pkg::STEP_FIRST;
        end
      end else if ((uw.jmp == asf_pkg::JMP_ALWAYS) ||
                   ((uw.jmp == asf_pkg::JMP_NO_POLY) && !poly_needed)) begin
        step_d = uw.target;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= asf_pkg::STEP_FIRST;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_accept) begin
      col_q  <= tick_i.data.target_column;
      hold_q <= tick_i.data.hold_sweep;
    end
  end

  // ------------------------------------------------------- elevation unit
  asf_poly u_poly (
    .clk_i      (clk_i),
    .uword_i    (uw_eff),
    .dist_i     (dist_q),
    .elev_mag_o (elev_mag),
    .elev_neg_o (elev_neg)
  );

  // ----------------------------------------------------------- update step
  assign col_diff = $signed({1'b0, col_q}) - $signed({1'b0, aim_q});

  always_comb begin
    sweep_angle_d  = sweep_angle_q;
    sweep_tick_d   = sweep_tick_q;
    sweep_rising_d = sweep_rising_q;
    fire_phase_d   = fire_phase_q;
    phase_ticks_d  = phase_ticks_q;
    firing_d       = firing_q;
    charge_on_d    = charge_on_q;
    discharge_on_d = discharge_on_q;
    shoot_d        = shoot_q;
    pan_ang        = '0;
    pan_en         = 1'b1;
    tilt_mag       = '0;
    tilt_neg       = 1'b0;
    tilt_en        = 1'b1;

    case (mode_q)
      asf_pkg::MODE_MANUAL: begin
        if (run_q) begin
          // zero distance means zero elevation, polynomial was skipped
          if (dist_q != '0) begin
            tilt_mag = elev_mag;
            tilt_neg = elev_neg;
          end
          sweep_angle_d = 9'(man_pan_q);
          pan_ang       = 9'(man_pan_q);
          shoot_d       = 1'b1;
        end else begin
          sweep_angle_d = '0;
        end
      end
      asf_pkg::MODE_SWEEP: begin
        if (run_q) begin
          tilt_mag = TILT_FIXED;
          case (fire_phase_q)
            PH_DISCHARGE: begin
              discharge_on_d = 1'b1;
              phase_ticks_d  = phase_ticks_q + 8'd1;
              if (phase_ticks_d == DIS_TICKS) begin
                phase_ticks_d = '0;
                fire_phase_d  = PH_CHARGE;
              end
            end
            PH_CHARGE: begin
              discharge_on_d = 1'b0;
              charge_on_d    = 1'b1;
              phase_ticks_d  = phase_ticks_q + 8'd1;
              if (phase_ticks_d == CHG_TICKS) begin
                phase_ticks_d = '0;
                fire_phase_d  = PH_SETTLE;
              end
            end
            PH_SETTLE: begin
              charge_on_d   = 1'b0;
              phase_ticks_d = phase_ticks_q + 8'd1;
              if (phase_ticks_d == SETTLE_TICKS) begin
                phase_ticks_d = '0;
                fire_phase_d  = PH_ARMED;
              end
            end
            PH_DONE: begin
              discharge_on_d = 1'b0;
              firing_d       = 1'b0;
            end
            default: ;
          endcase

          if (hold_q) begin
            // sweep, window check and fire count frozen, pan untouched
            pan_en = 1'b0;
          end else begin
            sweep_tick_d = sweep_tick_q + 8'd1;
            if (sweep_rising_q) begin
              if (sweep_tick_d == SWEEP_PERIOD) begin
                sweep_angle_d = sweep_angle_q + SWEEP_STEP;
                sweep_tick_d  = '0;
              end
              if (sweep_angle_d >= SWEEP_LIMIT) begin
                sweep_rising_d = 1'b0;
              end
            end else begin
              if (sweep_tick_d == SWEEP_PERIOD) begin
                sweep_angle_d = sweep_angle_q - SWEEP_STEP;
                sweep_tick_d  = '0;
              end
              if (sweep_angle_d <= -SWEEP_LIMIT) begin
                sweep_rising_d = 1'b1;
              end
            end
            // target inside the window while armed
            if ((col_diff < WINDOW) && (col_diff > -WINDOW) && (fire_phase_d == PH_ARMED)) begin
              discharge_on_d = 1'b1;
              firing_d       = 1'b1;
            end
            if (firing_d) begin
              phase_ticks_d = phase_ticks_d + 8'd1;
              if (phase_ticks_d == FIRE_TICKS) begin
                phase_ticks_d = '0;
                fire_phase_d  = PH_DONE;
              end
            end
            pan_ang = sweep_angle_d;
          end
        end else begin
          // parked: level tilt, pan at the left end of the sweep
          sweep_angle_d = -SWEEP_LIMIT;
          pan_ang       = -SWEEP_LIMIT;
        end
      end
      default: begin
        // idle and the unused selector: both centered
        sweep_angle_d = '0;
      end
    endcase
  end

  // angles of forty degrees or more leave the compare alone
  assign tilt_small = {1'b0, tilt_mag[5:0]};
  assign pan_go_d   = pan_en && (pan_ang < ANGLE_LIMIT) && (pan_ang > -ANGLE_LIMIT);
  assign pan_tgt_d  = pan_ang[asf_pkg::TgtW-1:0];
  assign tilt_go_d  = tilt_en && (tilt_mag < ELEV_LIMIT);
  assign tilt_tgt_d = tilt_neg ? -tilt_small : tilt_small;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_angle_q  <= '0;
      sweep_tick_q   <= '0;
      sweep_rising_q <= 1'b0;
      fire_phase_q   <= PH_DISCHARGE;
      phase_ticks_q  <= '0;
      firing_q       <= 1'b0;
      charge_on_q    <= 1'b0;
      discharge_on_q <= 1'b0;
      shoot_q        <= 1'b0;
      pan_go_q       <= 1'b0;
      tilt_go_q      <= 1'b0;
    end else if (do_update) begin
      sweep_angle_q  <= sweep_angle_d;
      sweep_tick_q   <= sweep_tick_d;
      sweep_rising_q <= sweep_rising_d;
      fire_phase_q   <= fire_phase_d;
      phase_ticks_q  <= phase_ticks_d;
      firing_q       <= firing_d;
      charge_on_q    <= charge_on_d;
      discharge_on_q <= discharge_on_d;
      shoot_q        <= shoot_d;
      pan_go_q       <= pan_go_d;
      tilt_go_q      <= tilt_go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_update) begin
      pan_tgt_q  <= pan_tgt_d;
      tilt_tgt_q <= tilt_tgt_d;
    end
  end

  // ------------------------------------------------------------ servo step
  assign pan_value_d  = pan_go_q ? asf_pkg::to_compare(pan_ctr_q, pan_tgt_q) : pan_value_q;
  assign tilt_value_d = tilt_go_q ? asf_pkg::to_compare(tilt_ctr_q, tilt_tgt_q) : tilt_value_q;

  always_comb begin
    out_d.pan_compare     = pan_value_d;
    out_d.tilt_compare    = tilt_value_d;
    out_d.charge_relay    = charge_on_q;
    out_d.discharge_relay = discharge_on_q;
    out_d.shoot_request   = shoot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_value_q  <= 15'd1680;
      tilt_value_q <= 15'd1300;
      out_valid_q  <= 1'b0;
    end else begin
      if (servo_fire) begin
        pan_value_q  <= pan_value_d;
        tilt_value_q <= tilt_value_d;
        out_valid_q  <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (servo_fire) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  // ------------------------------------------------------------ assertions
  `ASF_ASSERT_NXT(a_accept_starts_program, clk_i, rst_ni, tick_accept, busy_q && (step_q == asf_pkg::STEP_FIRST), "accepted item did not start the program at its first step")
  `ASF_ASSERT_IMP(a_step_in_program, clk_i, rst_ni, busy_q, step_q <= asf_pkg::STEP_SERVO, "step counter ran past the servo step")
  `ASF_ASSERT_IMP(a_result_from_servo, clk_i, rst_ni, $rose(out_valid_q), $past(servo_fire), "result appeared without a servo step")
  `ASF_ASSERT_IMP(a_relays_exclusive, clk_i, rst_ni, charge_on_q, !discharge_on_q, "charge and discharge relays on together")

endmodule

// ===== bench/aim_sweep_and_fire_sequencer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aim_sweep_and_fire_sequencer_test
// self-checking bench: a local servo and relay predictor runs on every
// accepted tick item and each result item is compared field by field, with
// random gaps on the tick side and random stalls on the result side
// ----------------------------------------------------------------------------
module aim_sweep_and_fire_sequencer_test;

  // spare selector code, behaves like idle
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // elevation polynomial in q24, horner order, signs applied where used
  localparam longint ELEV_K5   = 64'sd3028287;
  localparam longint ELEV_K4   = 64'sd35517366;
  localparam longint ELEV_K3   = 64'sd174650819;
  localparam longint ELEV_K2   = 64'sd445602857;
  localparam longint ELEV_K1   = 64'sd748599378;
  localparam longint ELEV_K0   = 64'sd470600909;
  localparam longint HORNER_MAX = 64'sd549755813887;

  localparam int ANGLE_LIMIT   = 40;
  localparam int CMP_CEIL      = 32767;
  localparam int SWEEP_EDGE    = 30;
  localparam int SWEEP_STEP    = 2;
  localparam int SWEEP_PERIOD  = 6;
  localparam int FIXED_TILT    = 20;
  localparam int AIM_WINDOW    = 55;
  localparam int DISCHARGE_TICKS = 20;
  localparam int CHARGE_TICKS  = 150;
  localparam int SETTLE_TICKS  = 100;
  localparam int FIRE_TICKS    = 100;

  localparam int ITEM_TARGET   = 1800;
  localparam int IDLE_GUARD    = 4;    // cycles of quiet before a register write
  localparam int TAIL_CYCLES   = 40;   // cycles of quiet after the last test
  localparam int LIMIT_CYCLES  = 600000;

  // relay sequence position in sweep-fire mode
  typedef enum logic [2:0] {
    PH_DISCHARGE = 3'd1,
    PH_CHARGE    = 3'd2,
    PH_SETTLE    = 3'd3,
    PH_ARMED     = 3'd4,
    PH_DONE      = 3'd5
  } relay_phase_e;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [asf_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [asf_pkg::CfgDataW-1:0] cfg_data;

  asf_tick_if   tick_ch ();
  asf_result_if result_ch ();

  aim_sweep_and_fire_sequencer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .tick_i     (tick_ch),
    .result_o   (result_ch)
  );

  // shadow of the register file, follows every write
  logic [1:0]                cfg_mode        = asf_pkg::MODE_IDLE;
  logic                      cfg_run         = 1'b0;
  logic [asf_pkg::DistW-1:0] cfg_distance    = '0;
  logic signed [7:0]         cfg_manual_pan  = '0;
  logic [asf_pkg::ColW-1:0]  cfg_aim_column  = 10'd183;
  logic [asf_pkg::CmpW-1:0]  cfg_pan_center  = 15'd1680;
  logic [asf_pkg::CmpW-1:0]  cfg_tilt_center = 15'd1300;

  // predicted servo and relay state, starts at the reset values
  logic [asf_pkg::CmpW-1:0] pan_cmp      = 15'd1680;
  logic [asf_pkg::CmpW-1:0] tilt_cmp     = 15'd1300;
  int              sweep_deg    = 0;   // wider than the sweep needs: manual copies its angle
  logic [7:0]      sweep_cnt    = '0;
  logic            sweep_up     = 1'b0;
  relay_phase_e    relay_phase  = PH_DISCHARGE;
  logic [7:0]      phase_cnt    = '0;
  logic            shot_active  = 1'b0;
  logic            charge_st    = 1'b0;
  logic            discharge_st = 1'b0;
  logic            shoot_st     = 1'b0;

  asf_pkg::asf_result_t awaited_outputs[$];
  int          ticks_sent  = 0;
  int          n_fail      = 0;
  int          cycle_count = 0;
  bit          rush_mode   = 1'b0;   // both sides run without gaps while set

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog, far above the slowest legal run
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("no progress after %0d cycles", LIMIT_CYCLES);
    $display("FAIL aim_sweep_and_fire_sequencer");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // q24 product with the fraction truncated toward zero
  function automatic longint q24_mul(input longint h, input longint unsigned d);
    longint unsigned m, r;
    m = (h < 0) ? -h : h;
    r = (m >> 24) * d + (((m & 64'hFF_FFFF) * d) >> 24);
    return (h < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint horner_sat(input longint v);
    if (v > HORNER_MAX) return HORNER_MAX;
    if (v < -HORNER_MAX) return -HORNER_MAX;
    return v;
  endfunction

  // tilt angle in whole degrees for a distance in cm, truncated toward zero
  function automatic int elevation_deg(input logic [asf_pkg::DistW-1:0] dist_cm);
    longint unsigned d, m;
    longint h;
    if (dist_cm == 0) return 0;
    d = dist_cm;
    d = (d << 24) / 100;   // meters in q24, floored
    h = ELEV_K5;
    h = horner_sat(q24_mul(h, d) - ELEV_K4);
    h = horner_sat(q24_mul(h, d) + ELEV_K3);
    h = horner_sat(q24_mul(h, d) - ELEV_K2);
    h = horner_sat(q24_mul(h, d) + ELEV_K1);
    h = horner_sat(q24_mul(h, d) - ELEV_K0);
    m = (h < 0) ? -h : h;
    return (h < 0) ? -int'(m >> 24) : int'(m >> 24);
  endfunction

  // new compare for an angle; out-of-range angles keep the old compare
  function automatic logic [asf_pkg::CmpW-1:0] servo_aim(
      input logic [asf_pkg::CmpW-1:0] cur,
      input logic [asf_pkg::CmpW-1:0] center,
      input int deg);
    int v;
    if (deg >= ANGLE_LIMIT || deg <= -ANGLE_LIMIT) return cur;
    // 1000/135 compare counts per degree, division truncates toward zero
    v = int'(center) + (deg * 1000) / 135;
    if (v < 0) v = 0;
    else if (v > CMP_CEIL) v = CMP_CEIL;
    return v[asf_pkg::CmpW-1:0];
  endfunction

  // one control tick: advance the shadow state and return the outputs
  function automatic asf_pkg::asf_result_t predict_tick(
      input logic [asf_pkg::ColW-1:0] column,
      input logic hold);
    asf_pkg::asf_result_t r;
    int col_diff;
    if (cfg_mode == asf_pkg::MODE_MANUAL && cfg_run) begin
      tilt_cmp  = servo_aim(tilt_cmp, cfg_tilt_center, elevation_deg(cfg_distance));
      sweep_deg = cfg_manual_pan;
      pan_cmp   = servo_aim(pan_cmp, cfg_pan_center, cfg_manual_pan);
      shoot_st  = 1'b1;
    end else if (cfg_mode == asf_pkg::MODE_SWEEP && !cfg_run) begin
      // parked at the sweep start, relays hold
      sweep_deg = -SWEEP_EDGE;
      tilt_cmp  = servo_aim(tilt_cmp, cfg_tilt_center, 0);
      pan_cmp   = servo_aim(pan_cmp, cfg_pan_center, sweep_deg);
    end else if (cfg_mode == asf_pkg::MODE_SWEEP) begin
      tilt_cmp = servo_aim(tilt_cmp, cfg_tilt_center, FIXED_TILT);
      case (relay_phase)
        PH_DISCHARGE: begin
          discharge_st = 1'b1;
          phase_cnt++;
          if (phase_cnt == DISCHARGE_TICKS) begin
            phase_cnt   = '0;
            relay_phase = PH_CHARGE;
          end
        end
        PH_CHARGE: begin
          discharge_st = 1'b0;
          charge_st    = 1'b1;
          phase_cnt++;
          if (phase_cnt == CHARGE_TICKS) begin
            phase_cnt   = '0;
            relay_phase = PH_SETTLE;
          end
        end
        PH_SETTLE: begin
          charge_st = 1'b0;
          phase_cnt++;
          if (phase_cnt == SETTLE_TICKS) begin
            phase_cnt   = '0;
            relay_phase = PH_ARMED;
          end
        end
        PH_DONE: begin
          discharge_st = 1'b0;
          shot_active  = 1'b0;
        end
        default: ;
      endcase
      // hold freezes the sweep, the window check and the shot count
      if (!hold) begin
        sweep_cnt++;
        if (sweep_up) begin
          if (sweep_cnt == SWEEP_PERIOD) begin
            sweep_deg += SWEEP_STEP;
            sweep_cnt  = '0;
          end
          if (sweep_deg >= SWEEP_EDGE) sweep_up = 1'b0;
        end else begin
          if (sweep_cnt == SWEEP_PERIOD) begin
            sweep_deg -= SWEEP_STEP;
            sweep_cnt  = '0;
          end
          if (sweep_deg <= -SWEEP_EDGE) sweep_up = 1'b1;
        end
        col_diff = int'(column) - int'(cfg_aim_column);
        if (col_diff < AIM_WINDOW && col_diff > -AIM_WINDOW && relay_phase == PH_ARMED) begin
          discharge_st = 1'b1;
          shot_active  = 1'b1;
        end
        if (shot_active) begin
          phase_cnt++;
          if (phase_cnt == FIRE_TICKS) begin
            phase_cnt   = '0;
            relay_phase = PH_DONE;
          end
        end
        pan_cmp = servo_aim(pan_cmp, cfg_pan_center, sweep_deg);
      end
    end else begin
      // idle, spare selector and manual not running all center the servos
      pan_cmp   = cfg_pan_center;
      tilt_cmp  = cfg_tilt_center;
      sweep_deg = 0;
    end
    r.pan_compare     = pan_cmp;
    r.tilt_compare    = tilt_cmp;
    r.charge_relay    = charge_st;
    r.discharge_relay = discharge_st;
    r.shoot_request   = shoot_st;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int draw_gap();
    return rush_mode ? 0 : $urandom_range(0, 6);
  endfunction

  // register values with the extremes weighted in
  function automatic logic [asf_pkg::CfgDataW-1:0] draw_reg_value(input asf_pkg::asf_reg_e idx);
    int pick, deg;
    logic [asf_pkg::CfgDataW-1:0] v;
    pick = $urandom_range(0, 9);
    case (idx)
      asf_pkg::REG_TARGET_DISTANCE_CM:
        v = (pick == 0) ? 0 : (pick == 1) ? 999 : (pick == 2) ? 1023 :
            $urandom_range(1, 999);
      asf_pkg::REG_MANUAL_PAN_DEGREES: begin
        // mostly around the +-40 cutoff
        deg = (pick == 0) ? -128 : (pick == 1) ? 127 : int'($urandom_range(0, 90)) - 45;
        v   = deg & 'hFF;
      end
      asf_pkg::REG_AIM_COLUMN:
        v = (pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(0, 1023);
      asf_pkg::REG_PAN_CENTER, asf_pkg::REG_TILT_CENTER:
        // small centers push negative angles into the floor
        v = (pick == 0) ? 0 : (pick == 1) ? CMP_CEIL : (pick == 2) ? $urandom_range(0, 300) :
            $urandom_range(0, 19999);
      default: v = $urandom_range(0, 1);
    endcase
    return v;
  endfunction

  // target column; while armed, steer toward the window and its edges
  function automatic logic [asf_pkg::ColW-1:0] pick_column();
    int aim, c, r;
    aim = int'(cfg_aim_column);
    r   = $urandom_range(0, 99);
    c   = $urandom_range(0, 1023);
    if (relay_phase == PH_ARMED && !shot_active) begin
      if (r < 6) begin
        c = aim + int'($urandom_range(0, 108)) - 54;
      end else if (r < 16) begin
        c = (r < 11) ? aim + AIM_WINDOW : aim - AIM_WINDOW;
      end else if (c - aim < AIM_WINDOW && c - aim > -AIM_WINDOW) begin
        c = (aim >= 512) ? 0 : 1023;
      end
      if (c < 0) c = 0;
      else if (c > 1023) c = 1023;
    end
    return c[asf_pkg::ColW-1:0];
  endfunction

  // write one register; the shadow copy changes at the same edge
  task automatic write_reg(input asf_pkg::asf_reg_e idx,
                           input logic [asf_pkg::CfgDataW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    case (idx)
      asf_pkg::REG_MODE_SELECT:        cfg_mode        = value[1:0];
      asf_pkg::REG_RUN_ENABLE:         cfg_run         = value[0];
      asf_pkg::REG_TARGET_DISTANCE_CM: cfg_distance    = value[asf_pkg::DistW-1:0];
      asf_pkg::REG_MANUAL_PAN_DEGREES: cfg_manual_pan  = value[7:0];
      asf_pkg::REG_AIM_COLUMN:         cfg_aim_column  = value[asf_pkg::ColW-1:0];
      asf_pkg::REG_PAN_CENTER:         cfg_pan_center  = value;
      asf_pkg::REG_TILT_CENTER:        cfg_tilt_center = value;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one tick item after a random gap; predict it once accepted
  task automatic send_tick(input logic [asf_pkg::ColW-1:0] column, input logic hold);
    asf_pkg::asf_tick_t item;
    int gap;
    item.target_column = column;
    item.hold_sweep    = hold;
    gap = draw_gap();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= item;
    do @(posedge clk_i); while (!tick_ch.ready);
    awaited_outputs.push_back(predict_tick(column, hold));
    ticks_sent++;
  endtask

  // stop offering and wait until every result item is back
  task automatic settle();
    tick_ch.valid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk_i);
    repeat (IDLE_GUARD) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, compare with the oldest prediction
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    asf_pkg::asf_result_t want, got;
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
      got = result_ch.data;
      if (awaited_outputs.size() == 0) begin
        $error("result item with no tick item pending");
        n_fail++;
      end else begin
        want = awaited_outputs.pop_front();
        if (got.pan_compare !== want.pan_compare) begin
          $error("pan_compare expected %0d got %0d", want.pan_compare, got.pan_compare);
          n_fail++;
        end
        if (got.tilt_compare !== want.tilt_compare) begin
          $error("tilt_compare expected %0d got %0d", want.tilt_compare, got.tilt_compare);
          n_fail++;
        end
        if (got.charge_relay !== want.charge_relay) begin
          $error("charge_relay expected %0b got %0b", want.charge_relay, got.charge_relay);
          n_fail++;
        end
        if (got.discharge_relay !== want.discharge_relay) begin
          $error("discharge_relay expected %0b got %0b",
                 want.discharge_relay, got.discharge_relay);
          n_fail++;
        end
        if (got.shoot_request !== want.shoot_request) begin
          $error("shoot_request expected %0b got %0b", want.shoot_request, got.shoot_request);
          n_fail++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values, then the spare selector code
  task automatic test_idle_centers();
    send_tick('0, 1'b0);
    send_tick('1, 1'b1);
    send_tick(10'h2AA, 1'b0);
    settle();
    write_reg(asf_pkg::REG_MODE_SELECT, MODE_SPARE);
    send_tick(10'h155, 1'b1);
    settle();
  endtask

  // manual aim: stopped, polynomial distances, angle cutoff, saturation
  task automatic test_manual_aim();
    int dists[7] = '{0, 999, 1, 1023, 250, 500, 120};
    int pans[7]  = '{0, 39, -39, 40, -40, 127, -128};
    write_reg(asf_pkg::REG_MODE_SELECT, asf_pkg::MODE_MANUAL);
    write_reg(asf_pkg::REG_RUN_ENABLE, 1'b0);
    send_tick(10'd183, 1'b0);
    settle();
    write_reg(asf_pkg::REG_RUN_ENABLE, 1'b1);
    for (int k = 0; k < 7; k++) begin
      write_reg(asf_pkg::REG_TARGET_DISTANCE_CM, dists[k]);
      write_reg(asf_pkg::REG_MANUAL_PAN_DEGREES, pans[k] & 'hFF);
      send_tick($urandom_range(0, 1023), k[0]);
      settle();
    end
    // compares clipped at zero
    write_reg(asf_pkg::REG_PAN_CENTER, 0);
    write_reg(asf_pkg::REG_TILT_CENTER, 0);
    write_reg(asf_pkg::REG_MANUAL_PAN_DEGREES, -39 & 'hFF);
    write_reg(asf_pkg::REG_TARGET_DISTANCE_CM, 100);
    send_tick('0, 1'b0);
    settle();
    // compares clipped at the top of the field
    write_reg(asf_pkg::REG_PAN_CENTER, CMP_CEIL);
    write_reg(asf_pkg::REG_TILT_CENTER, CMP_CEIL);
    write_reg(asf_pkg::REG_MANUAL_PAN_DEGREES, 39);
    write_reg(asf_pkg::REG_TARGET_DISTANCE_CM, 300);
    send_tick('1, 1'b1);
    settle();
    write_reg(asf_pkg::REG_PAN_CENTER, 1680);
    write_reg(asf_pkg::REG_TILT_CENTER, 1300);
  endtask

  // sweep selected but not running: parked at -30 with tilt level
  task automatic test_sweep_stopped();
    write_reg(asf_pkg::REG_MODE_SELECT, asf_pkg::MODE_SWEEP);
    write_reg(asf_pkg::REG_RUN_ENABLE, 1'b0);
    send_tick('0, 1'b0);
    send_tick('1, 1'b1);
    settle();
  endtask

  // the one-time relay sequence through to the shot and beyond, with pauses
  // in other modes or with run disabled that must leave the sequence where it was
  task automatic test_fire_sequence();
    int after_done, run_len;
    after_done = 0;
    write_reg(asf_pkg::REG_RUN_ENABLE, 1'b1);
    while (after_done < 80) begin
      rush_mode = ($urandom_range(0, 3) == 0);
      run_len   = $urandom_range(5, 60);
      repeat (run_len) begin
        send_tick(pick_column(), (relay_phase == PH_ARMED) ? ($urandom_range(0, 2) == 0) :
                                                             ($urandom_range(0, 4) == 0));
        if (relay_phase == PH_DONE) after_done++;
      end
      if ($urandom_range(0, 3) == 0) begin
        settle();
        if ($urandom_range(0, 1)) begin
          write_reg(asf_pkg::REG_RUN_ENABLE, 1'b0);
        end else begin
          write_reg(asf_pkg::REG_MODE_SELECT,
                    $urandom_range(0, 1) ? asf_pkg::MODE_IDLE : asf_pkg::MODE_MANUAL);
        end
        if ($urandom_range(0, 1)) begin
          write_reg(asf_pkg::REG_AIM_COLUMN, draw_reg_value(asf_pkg::REG_AIM_COLUMN));
        end
        repeat ($urandom_range(1, 8)) send_tick($urandom_range(0, 1023), $urandom_range(0, 1));
        settle();
        write_reg(asf_pkg::REG_MODE_SELECT, asf_pkg::MODE_SWEEP);
        write_reg(asf_pkg::REG_RUN_ENABLE, 1'b1);
      end
    end
    settle();
  endtask

  // random settings, each followed by a burst of random tick items
  task automatic test_random_mix();
    int r, run_len;
    logic [1:0] mode;
    while (ticks_sent < ITEM_TARGET) begin
      settle();
      rush_mode = ($urandom_range(0, 4) == 0);
      r    = $urandom_range(0, 19);
      mode = (r < 2) ? asf_pkg::MODE_IDLE : (r < 9) ? asf_pkg::MODE_MANUAL :
             (r < 18) ? asf_pkg::MODE_SWEEP : MODE_SPARE;
      write_reg(asf_pkg::REG_MODE_SELECT, mode);
      write_reg(asf_pkg::REG_RUN_ENABLE, $urandom_range(0, 4) != 0);
      for (int k = asf_pkg::REG_TARGET_DISTANCE_CM; k <= asf_pkg::REG_TILT_CENTER; k++) begin
        if ($urandom_range(0, 4) < 2) begin
          write_reg(asf_pkg::asf_reg_e'(k), draw_reg_value(asf_pkg::asf_reg_e'(k)));
        end
      end
      run_len = $urandom_range(1, 40);
      repeat (run_len) send_tick($urandom_range(0, 1023), $urandom_range(0, 3) == 0);
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= asf_pkg::REG_MODE_SELECT;
    cfg_data        <= '0;
    tick_ch.valid   <= 1'b0;
    tick_ch.data    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_centers();
    test_manual_aim();
    test_sweep_stopped();
    test_fire_sequence();
    test_random_mix();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("PASS aim_sweep_and_fire_sequencer");
    end else begin
      $display("FAIL aim_sweep_and_fire_sequencer");
    end
    $finish;
  end

endmodule
